@@ sv/rqm_pkg.sv @@
package rqm_pkg;

   localparam int unsigned DEF_CAPACITY = 64;

   localparam int unsigned CMD_W         = 2;
   localparam int unsigned PID_W         = 16;
   localparam int unsigned BURST_W       = 16;
   localparam int unsigned STATUS_W      = 3;
   localparam int unsigned ENTRY_COUNT_W = 7;
   localparam int unsigned LOAD_W        = 22;

   localparam logic [PID_W-1:0] MARKER_PID = '1;

   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SORT    = 2'd3;

   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] STS_MARKER    = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd4;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_SORT   = 2'd3
   } op_type;

   typedef struct packed {
      logic [PID_W-1:0]   pid;
      logic [BURST_W-1:0] burst;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type ent;
   } tok_type;

   // signals rippling from head to tail through the row
   typedef struct packed {
      logic      hit;
      logic      tail_mark;
      logic      tok_done;
      entry_type sel;
      entry_type fin;
   } chain_type;

   typedef struct packed {
      logic             key_mode;
      logic             head_mode;
      logic [PID_W-1:0] key;
   } match_type;

   typedef struct packed {
      op_type    op;
      logic      launch;
      logic      wb;
      entry_type new_ent;
      entry_type wb_ent;
   } cell_ctrl_type;

endpackage

@@ sv/rqm_cell.sv @@
module rqm_cell #(
   parameter int unsigned CAPACITY = rqm_pkg::DEF_CAPACITY,
   parameter int unsigned IDX      = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rqm_pkg::cell_ctrl_type            ctrl,
   input  rqm_pkg::match_type                mtch,
   input  logic [$clog2(CAPACITY+1)-1:0]     count,
   input  logic [$clog2(CAPACITY+1)-1:0]     pos,
   input  logic [$clog2(CAPACITY)-1:0]       pass_idx,
   input  rqm_pkg::entry_type                left_ent,
   input  rqm_pkg::entry_type                right_ent,
   input  rqm_pkg::tok_type                  left_tok,
   input  rqm_pkg::chain_type                chain_in,
   output rqm_pkg::entry_type                ent,
   output rqm_pkg::tok_type                  tok,
   output rqm_pkg::chain_type                chain_out
);
   import rqm_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY+1);
   localparam int unsigned IW = $clog2(CAPACITY);
   localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
   localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);
   localparam logic [IW-1:0] MY_SLOT = IW'(IDX);
   localparam bit            IS_HEAD = (IDX == 0);

   entry_type ent_ff, ent_in;
   logic      tok_valid_ff, tok_valid_in;
   entry_type tok_ent_ff, tok_ent_in;

   logic occupied, is_last, match, first, here, exchange, launch_here;

   assign occupied    = MY_IDX < count;
   assign is_last     = count == MY_NEXT;
   assign here        = pass_idx == MY_SLOT;
   assign launch_here = ctrl.launch && here;
   assign exchange    = $signed(left_tok.ent.pid) > $signed(ent_ff.pid);
   assign match       = occupied && ((mtch.key_mode && ent_ff.pid == mtch.key) ||
                                     (mtch.head_mode && IS_HEAD));
   assign first       = match && !chain_in.hit;

   assign chain_out.hit       = chain_in.hit || match;
   assign chain_out.tail_mark = chain_in.tail_mark || (is_last && ent_ff.pid == MARKER_PID);
   assign chain_out.tok_done  = chain_in.tok_done || (tok_valid_ff && is_last);
   assign chain_out.sel       = first ? ent_ff : chain_in.sel;
   assign chain_out.fin       = (tok_valid_ff && is_last) ? tok_ent_ff : chain_in.fin;

   always_comb begin
      ent_in       = ent_ff;
      tok_valid_in = 1'b0;
      tok_ent_in   = tok_ent_ff;
      unique case (ctrl.op)
         OP_INSERT: begin
            if (MY_IDX > pos) begin
               ent_in = left_ent;
            end else if (MY_IDX == pos) begin
               ent_in = ctrl.new_ent;
            end
         end
         OP_REMOVE: begin
            if (chain_in.hit || match) begin
               ent_in = right_ent;
            end
         end
         OP_SORT: begin
            // compare-exchange as the sort token walks toward the tail
            if (ctrl.wb && here) begin
               ent_in = ctrl.wb_ent;
            end else if (left_tok.valid && occupied && exchange) begin
               ent_in = left_tok.ent;
            end
            tok_valid_in = (left_tok.valid && occupied) || launch_here;
            if (launch_here || exchange) begin
               tok_ent_in = ent_ff;
            end else begin
               tok_ent_in = left_tok.ent;
            end
         end
         OP_HOLD: begin
            ent_in = ent_ff;
         end
         default: begin
            ent_in = ent_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff     <= ent_in;
      tok_ent_ff <= tok_ent_in;
   end

   assign ent       = ent_ff;
   assign tok.valid = tok_valid_ff;
   assign tok.ent   = tok_ent_ff;

endmodule

@@ sv/ready_queue_with_marker.sv @@
// enqueue, dequeue and remove: beat accepted, an execute state, result strobe on the
//   following cycle; a new beat is taken only once busy has fallen again
// sort of n entries: busy while the single exchange token walks the cell row once
//   per pass; n below 2 behaves like the other commands
// rsp_strobe lasts one cycle and the receiver cannot stall it
// synchronous reset empties the queue, clears the load sum and returns to idle
module ready_queue_with_marker #(
   parameter int unsigned CAPACITY = rqm_pkg::DEF_CAPACITY
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [rqm_pkg::CMD_W-1:0]              req_cmd,
   input  logic signed [rqm_pkg::PID_W-1:0]       req_pid,
   input  logic [rqm_pkg::BURST_W-1:0]            req_burst_length,
   output logic                                   rsp_strobe,
   output logic [rqm_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [rqm_pkg::PID_W-1:0]       rsp_out_pid,
   output logic [rqm_pkg::BURST_W-1:0]            rsp_out_burst,
   output logic [rqm_pkg::ENTRY_COUNT_W-1:0]      rsp_entry_count,
   output logic [rqm_pkg::LOAD_W-1:0]             rsp_total_load
);
   import rqm_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY+1);
   localparam int unsigned IW = $clog2(CAPACITY);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_LAUNCH = 4'b0100,
      ST_WALK   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [LOAD_W-1:0] load_ff, load_in;
   logic [IW-1:0]     pass_idx_ff, pass_idx_in;

   logic [CMD_W-1:0]   cmd_ff;
   logic [PID_W-1:0]   key_ff;
   logic [BURST_W-1:0] burst_ff;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   entry_type           rsp_ent_ff, rsp_ent_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [LOAD_W-1:0]   rsp_load_ff, rsp_load_in;

   cell_ctrl_type ctrl;
   match_type     mtch;
   logic [CW-1:0] pos;

   entry_type ent_row   [0:CAPACITY+1];
   tok_type   tok_row   [0:CAPACITY];
   chain_type chain_row [0:CAPACITY];

   logic head_marker;
   logic last_pass;

   assign busy = state_ff != ST_IDLE;

   assign mtch.key_mode  = cmd_ff == CMD_REMOVE;
   assign mtch.head_mode = cmd_ff == CMD_DEQUEUE;
   assign mtch.key       = key_ff;

   assign ent_row[0]            = '0;
   assign ent_row[CAPACITY+1]   = ent_row[CAPACITY];
   assign tok_row[0]            = '0;
   assign chain_row[0]          = '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      rqm_cell #(
         .CAPACITY (CAPACITY),
         .IDX      (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .mtch      (mtch),
         .count     (count_ff),
         .pos       (pos),
         .pass_idx  (pass_idx_ff),
         .left_ent  (ent_row[g]),
         .right_ent (ent_row[g+2]),
         .left_tok  (tok_row[g]),
         .chain_in  (chain_row[g]),
         .ent       (ent_row[g+1]),
         .tok       (tok_row[g+1]),
         .chain_out (chain_row[g+1])
      );
   end

   assign head_marker = (count_ff != '0) && (ent_row[1].pid == MARKER_PID);
   assign last_pass   = ((CW+1)'(pass_idx_ff) + (CW+1)'(2)) >= (CW+1)'(count_ff);

   always_comb begin
      ctrl.op      = OP_HOLD;
      ctrl.launch  = 1'b0;
      ctrl.wb      = 1'b0;
      ctrl.new_ent = '{pid: key_ff, burst: burst_ff};
      ctrl.wb_ent  = chain_row[CAPACITY].fin;
      pos          = count_ff;
      state_in     = state_ff;
      count_in     = count_ff;
      load_in      = load_ff;
      pass_idx_in  = pass_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_ent_in    = rsp_ent_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = STS_OK;
            rsp_ent_in    = '0;
            state_in      = ST_IDLE;
            unique case (cmd_ff)
               CMD_ENQUEUE: begin
                  if (count_ff == CW'(CAPACITY)) begin
                     rsp_status_in = STS_FULL;
                  end else begin
                     ctrl.op = OP_INSERT;
                     if (count_ff == '0 || head_marker) begin
                        pos = '0;
                     end else if (chain_row[CAPACITY].tail_mark) begin
                        pos = count_ff - CW'(1);
                     end
                     count_in = count_ff + CW'(1);
                     load_in  = load_ff + LOAD_W'(burst_ff);
                  end
               end
               CMD_DEQUEUE, CMD_REMOVE: begin
                  if (count_ff == '0) begin
                     rsp_status_in = STS_EMPTY;
                  end else if (!chain_row[CAPACITY].hit) begin
                     rsp_status_in = STS_NOT_FOUND;
                  end else if (head_marker && (cmd_ff == CMD_DEQUEUE || key_ff == MARKER_PID)) begin
                     rsp_status_in = STS_MARKER;
                  end else begin
                     ctrl.op    = OP_REMOVE;
                     rsp_ent_in = chain_row[CAPACITY].sel;
                     count_in   = count_ff - CW'(1);
                     load_in    = load_ff - LOAD_W'(chain_row[CAPACITY].sel.burst);
                  end
               end
               CMD_SORT: begin
                  if (count_ff >= CW'(2)) begin
                     rsp_strobe_in = 1'b0;
                     pass_idx_in   = '0;
                     state_in      = ST_LAUNCH;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_LAUNCH: begin
            ctrl.op     = OP_SORT;
            ctrl.launch = 1'b1;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            ctrl.op = OP_SORT;
            if (chain_row[CAPACITY].tok_done) begin
               ctrl.wb = 1'b1;
               if (last_pass) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STS_OK;
                  rsp_ent_in    = '0;
                  state_in      = ST_IDLE;
               end else begin
                  pass_idx_in = pass_idx_ff + IW'(1);
                  state_in    = ST_LAUNCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_count_in = ENTRY_COUNT_W'(count_in);
      rsp_load_in  = load_in;
      if (!rsp_strobe_in) begin
         rsp_count_in = rsp_count_ff;
         rsp_load_in  = rsp_load_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         load_ff       <= '0;
         pass_idx_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         load_ff       <= load_in;
         pass_idx_ff   <= pass_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         cmd_ff   <= req_cmd;
         key_ff   <= req_pid;
         burst_ff <= req_burst_length;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_ent_ff    <= rsp_ent_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_load_ff   <= rsp_load_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_pid     = rsp_ent_ff.pid;
   assign rsp_out_burst   = rsp_ent_ff.burst;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_total_load  = rsp_load_ff;

`ifndef SYNTH
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_EXEC))
      else $error("accepted beat did not enter execute");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_EXEC || state_ff == ST_WALK))
      else $error("result strobe without finished command");

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !chain_row[CAPACITY].tok_done)
      else $error("sort token left in row while idle");
`endif

endmodule

@@ tb/testbench.sv @@
module testbench;
   import rqm_pkg::*;

   localparam int unsigned CAPACITY    = DEF_CAPACITY;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [PID_W-1:0]         pid;
      logic [BURST_W-1:0]       burst;
      logic [ENTRY_COUNT_W-1:0] count;
      logic [LOAD_W-1:0]        load;
   } queue_result_type;

   typedef enum logic [1:0] {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } traffic_mix_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [CMD_W-1:0]           req_cmd;
   logic signed [PID_W-1:0]    req_pid;
   logic [BURST_W-1:0]         req_burst_length;
   logic                       rsp_strobe;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [PID_W-1:0]    rsp_out_pid;
   logic [BURST_W-1:0]         rsp_out_burst;
   logic [ENTRY_COUNT_W-1:0]   rsp_entry_count;
   logic [LOAD_W-1:0]          rsp_total_load;

   entry_type                  queue_model[$];
   logic [LOAD_W-1:0]          load_model;
   queue_result_type           pending_results[$];
   int unsigned                fail_count;
   int unsigned                cycle_count;
   bit                         no_idle;

   ready_queue_with_marker #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_pid         (req_pid),
      .req_burst_length(req_burst_length),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_out_pid     (rsp_out_pid),
      .rsp_out_burst   (rsp_out_burst),
      .rsp_entry_count (rsp_entry_count),
      .rsp_total_load  (rsp_total_load)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // expected queue contents and result of one accepted command
   task automatic apply_queue_command(input logic [CMD_W-1:0] cmd,
                                      input logic [PID_W-1:0] pid,
                                      input logic [BURST_W-1:0] burst);
      queue_result_type res;
      entry_type        ent;
      entry_type        tmp;
      int               n;
      int               k;
      res = '0;
      n = queue_model.size();
      ent.pid = pid;
      ent.burst = burst;
      case (cmd)
         CMD_ENQUEUE: begin
            if (n >= CAPACITY) begin
               res.status = STS_FULL;
            end else begin
               if (n == 0 || queue_model[0].pid == MARKER_PID)
                  queue_model.push_front(ent);
               else if (queue_model[n-1].pid == MARKER_PID)
                  queue_model.insert(n - 1, ent);
               else
                  queue_model.push_back(ent);
               load_model = load_model + burst;
            end
         end
         CMD_DEQUEUE: begin
            if (n == 0) begin
               res.status = STS_EMPTY;
            end else if (queue_model[0].pid == MARKER_PID) begin
               res.status = STS_MARKER;
            end else begin
               res.pid = queue_model[0].pid;
               res.burst = queue_model[0].burst;
               load_model = load_model - queue_model[0].burst;
               void'(queue_model.pop_front());
            end
         end
         CMD_REMOVE: begin
            if (n == 0) begin
               res.status = STS_EMPTY;
            end else begin
               k = 0;
               while (k < n && queue_model[k].pid != pid)
                  k++;
               if (k == n) begin
                  res.status = STS_NOT_FOUND;
               end else if (k == 0 && pid == MARKER_PID) begin
                  res.status = STS_MARKER;
               end else begin
                  res.pid = queue_model[k].pid;
                  res.burst = queue_model[k].burst;
                  load_model = load_model - queue_model[k].burst;
                  queue_model.delete(k);
               end
            end
         end
         default: begin
            // exchange sort, not stable: equal pids may swap their bursts
            for (int i = 0; i + 1 < n; i++) begin
               for (int j = i + 1; j < n; j++) begin
                  if ($signed(queue_model[i].pid) > $signed(queue_model[j].pid)) begin
                     tmp = queue_model[i];
                     queue_model[i] = queue_model[j];
                     queue_model[j] = tmp;
                  end
               end
            end
         end
      endcase
      res.count = ENTRY_COUNT_W'(queue_model.size());
      res.load = load_model;
      pending_results.push_back(res);
   endtask

   always @(posedge clock) begin : result_check
      queue_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result beat: status %0d pid %0d burst %0d count %0d load %0d",
                        rsp_status, rsp_out_pid, rsp_out_burst, rsp_entry_count,
                        rsp_total_load);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status || rsp_out_pid !== want.pid ||
                rsp_out_burst !== want.burst || rsp_entry_count !== want.count ||
                rsp_total_load !== want.load) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"result beat differs at cycle %0d: expected status %0d pid %0d ",
                            "burst %0d count %0d load %0d, got status %0d pid %0d burst %0d ",
                            "count %0d load %0d"},
                           cycle_count, want.status, $signed(want.pid), want.burst,
                           want.count, want.load, rsp_status, rsp_out_pid, rsp_out_burst,
                           rsp_entry_count, rsp_total_load);
            end
         end
      end
   end

   // called and returns at a falling edge
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid,
                            input logic [BURST_W-1:0] burst);
      int unsigned gap;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 50)
         gap = 0;
      else if (roll < 85)
         gap = $urandom_range(1, 3);
      else if (roll < 95)
         gap = $urandom_range(4, 12);
      else
         gap = $urandom_range(20, 60);
      repeat (gap) @(negedge clock);
      start = 1'b1;
      req_cmd = cmd;
      req_pid = pid;
      req_burst_length = burst;
      do
         @(posedge clock);
      while (busy);
      apply_queue_command(cmd, pid, burst);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_for_results();
      while (pending_results.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [PID_W-1:0] rand_pid(input bit allow_marker);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (allow_marker && roll < 4)
         return MARKER_PID;
      else if (roll < 45)
         return PID_W'($urandom_range(0, 15));
      else if (roll < 55)
         return $urandom_range(0, 1) ? 16'sd32767 : 16'sd0;
      else
         return PID_W'($urandom_range(0, 32767));
   endfunction

   function automatic logic [BURST_W-1:0] rand_burst();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8)
         return '0;
      else if (roll < 16)
         return '1;
      else
         return BURST_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [PID_W-1:0] pick_present_pid();
      if (queue_model.size() > 0 && $urandom_range(0, 99) < 70)
         return queue_model[$urandom_range(0, queue_model.size() - 1)].pid;
      else
         return rand_pid(1'b1);
   endfunction

   task automatic test_empty_queue();
      send_beat(CMD_DEQUEUE, 16'sd0, 16'd0);
      send_beat(CMD_REMOVE, 16'sd0, 16'd0);
      send_beat(CMD_REMOVE, MARKER_PID, 16'hFFFF);
      send_beat(CMD_SORT, 16'sd32767, 16'hFFFF);
   endtask

   task automatic test_enqueue_dequeue();
      send_beat(CMD_ENQUEUE, 16'sd0, 16'd0);
      send_beat(CMD_SORT, 16'sd0, 16'd0);
      send_beat(CMD_ENQUEUE, 16'sd32767, 16'hFFFF);
      send_beat(CMD_REMOVE, 16'sd123, 16'd0);
      send_beat(CMD_REMOVE, 16'sd32767, 16'd0);
      send_beat(CMD_ENQUEUE, 16'h5555, 16'hAAAA);
      send_beat(CMD_ENQUEUE, 16'h2AAA, 16'h5555);
      send_beat(CMD_SORT, 16'sd0, 16'd0);
      send_beat(CMD_DEQUEUE, 16'sd0, 16'd0);
      send_beat(CMD_DEQUEUE, 16'sd0, 16'd0);
      send_beat(CMD_DEQUEUE, 16'sd0, 16'd0);
   endtask

   task automatic test_full_queue();
      // all bursts at maximum to reach the top of the load range
      while (queue_model.size() < CAPACITY)
         send_beat(CMD_ENQUEUE, rand_pid(1'b0), 16'hFFFF);
      send_beat(CMD_ENQUEUE, 16'sd32767, 16'hFFFF);
      send_beat(CMD_SORT, 16'sd0, 16'd0);
      send_beat(CMD_REMOVE, pick_present_pid(), 16'd0);
      send_beat(CMD_ENQUEUE, rand_pid(1'b0), rand_burst());
      send_beat(CMD_ENQUEUE, rand_pid(1'b0), rand_burst());
      while (queue_model.size() > 0) begin
         if ($urandom_range(0, 1))
            send_beat(CMD_DEQUEUE, rand_pid(1'b1), rand_burst());
         else
            send_beat(CMD_REMOVE, pick_present_pid(), rand_burst());
      end
   endtask

   task automatic test_marker_at_tail();
      send_beat(CMD_ENQUEUE, 16'sd100, 16'd7);
      send_beat(CMD_ENQUEUE, MARKER_PID, 16'd3);
      send_beat(CMD_ENQUEUE, 16'sd200, 16'd9);
      send_beat(CMD_REMOVE, MARKER_PID, 16'd0);
      send_beat(CMD_DEQUEUE, 16'sd0, 16'd0);
      send_beat(CMD_DEQUEUE, 16'sd0, 16'd0);
   endtask

   // drain the queue, then work with a marker at the head
   task automatic test_marker_at_head();
      while (queue_model.size() > 0)
         send_beat(CMD_DEQUEUE, rand_pid(1'b1), rand_burst());
      send_beat(CMD_ENQUEUE, MARKER_PID, 16'd11);
      send_beat(CMD_DEQUEUE, 16'sd0, 16'd0);
      send_beat(CMD_REMOVE, MARKER_PID, 16'd0);
      send_beat(CMD_REMOVE, 16'sd77, 16'd0);
      send_beat(CMD_ENQUEUE, 16'sd5, 16'd1);
      send_beat(CMD_ENQUEUE, 16'sd3, 16'd2);
      send_beat(CMD_SORT, 16'sd0, 16'd0);
      send_beat(CMD_REMOVE, 16'sd5, 16'd0);
      send_beat(CMD_DEQUEUE, 16'sd0, 16'd0);
   endtask

   task automatic test_random_traffic(input int unsigned n_items, input bit allow_marker);
      traffic_mix_type mix;
      int unsigned     roll;
      int unsigned     enq_share;
      mix = MIX_EVEN;
      enq_share = 50;
      for (int unsigned i = 0; i < n_items; i++) begin
         if (i % 50 == 0) begin
            mix = traffic_mix_type'($urandom_range(0, 2));
            no_idle = ($urandom_range(0, 3) == 0);
            enq_share = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 30 : 52;
         end
         if (i == n_items / 2)
            wait_for_results();
         roll = $urandom_range(0, 99);
         if (roll < 6)
            send_beat(CMD_SORT, rand_pid(1'b1), rand_burst());
         else if (roll < 6 + enq_share)
            send_beat(CMD_ENQUEUE, rand_pid(allow_marker), rand_burst());
         else if (roll % 2 == 0)
            send_beat(CMD_DEQUEUE, rand_pid(1'b1), rand_burst());
         else
            send_beat(CMD_REMOVE, pick_present_pid(), rand_burst());
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_ENQUEUE;
      req_pid = '0;
      req_burst_length = '0;
      load_model = '0;
      fail_count = 0;
      cycle_count = 0;
      no_idle = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_enqueue_dequeue();
      test_full_queue();
      test_marker_at_tail();
      test_random_traffic(260, 1'b0);
      test_marker_at_head();
      test_random_traffic(70, 1'b1);

      wait_for_results();
      repeat (16) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
